// ===== sv/base64_stream_decoder_core_macros.svh =====
// Assertion macros shared by the decoder modules.
// Each macro samples on the rising edge of clock; the checked module must
// have ports named clock and reset.
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// Check a property, ignored while reset is high.
`define B64D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

   // Default depth of the job queue between front and back.
   localparam int JOB_DEPTH_DEFAULT = 4;

   // Character codes of the alphabet ranges.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   // Sextet offsets of the lower-case and digit ranges, and the sextets of plus and slash.
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   // Number of results a job carries.
   localparam logic [1:0] NRES_ONE   = 2'd1;
   localparam logic [1:0] NRES_TWO   = 2'd2;
   localparam logic [1:0] NRES_THREE = 2'd3;

   // One request: an encoded character.
   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_text;
   } req_type;

   // One response: a decoded byte.
   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       last;
   } rsp_type;

   // One job: up to three responses of one request, oldest byte high.
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  nres;
      logic        valid;
      logic        last;
   } job_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Map a character to {in alphabet, sextet}.
   function automatic logic [6:0] sextet_of(logic [7:0] c);
      logic [7:0] d;
      logic [6:0] r;
      d = 8'h00;
      r = 7'h00;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         r = {1'b1, d[5:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + LOWER_BASE;
         r = {1'b1, d[5:0]};
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0 + DIGIT_BASE;
         r = {1'b1, d[5:0]};
      end else if (c == CHAR_PLUS) begin
         r = {1'b1, SEXTET_PLUS};
      end else if (c == CHAR_SLASH) begin
         r = {1'b1, SEXTET_SLASH};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/base64_stream_decoder_core.sv =====
`default_nettype none

// Base64 stream decoder, standard alphabet. One character enters per cycle
// while req_full is low; the front end classifies it and keeps the partial
// group, and each request that yields output places one job (one to three
// bytes) into a job queue of JOB_DEPTH entries. The back end sends one byte
// per cycle through a registered output while the consumer pops, so a full
// group of four characters gives three responses and the stream runs at one
// character per cycle. The first byte of a request passes the job queue and
// the current-job register into the output register, when the back end is
// idle. req_full rises only while the job queue is full, which happens when
// the consumer holds pop low. The first '=' or any foreign character stops
// decoding until end_of_text; the request that ends a string gives its
// remaining bytes with last set on the final one, or a single response with
// byte_valid low and last high when there is nothing to send.
module base64_stream_decoder_core #(
   parameter int JOB_DEPTH = b64d_pkg::JOB_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire b64d_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output b64d_pkg::rsp_type      rsp_data
);
   import b64d_pkg::*;

   q_stat_type q_stat;
   logic       job_push, job_pop;
   job_type    job_in, job_out;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_stat   (q_stat),
      .job_push (job_push),
      .job_data (job_in)
   );

   b64d_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .pop       (job_pop),
      .pop_data  (job_out),
      .stat      (q_stat)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .job_data  (job_out),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/b64d_front.sv =====
`default_nettype none

module b64d_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire b64d_pkg::req_type    req_data,
   input  wire b64d_pkg::q_stat_type q_stat,
   output logic                      job_push,
   output b64d_pkg::job_type         job_data
);
   import b64d_pkg::*;

   logic [1:0]  group_count_ff, group_count_in;
   logic [17:0] sextet_store_ff, sextet_store_in;
   logic        halted_ff, halted_in;

   logic        accept;
   logic [6:0]  sx;
   logic [1:0]  gc_step;
   logic [17:0] st_step;
   logic        full_group;

   // Stall the requester while the job queue is full.
   assign req_full = q_stat.full;
   assign accept   = req_push && !q_stat.full;
   assign sx       = sextet_of(req_data.char_in);

   // Classify the character and advance the group.
   always_comb begin
      gc_step    = group_count_ff;
      st_step    = sextet_store_ff;
      halted_in  = halted_ff;
      full_group = 1'b0;
      if (!halted_ff) begin
         if (!sx[6]) begin
            halted_in = 1'b1;
         end else if (group_count_ff == 2'd3) begin
            full_group = 1'b1;
            gc_step    = 2'd0;
            st_step    = 18'd0;
         end else begin
            st_step = {sextet_store_ff[11:0], sx[5:0]};
            gc_step = group_count_ff + 2'd1;
         end
      end
      group_count_in  = gc_step;
      sextet_store_in = st_step;
      if (req_data.end_of_text) begin
         group_count_in  = 2'd0;
         sextet_store_in = 18'd0;
         halted_in       = 1'b0;
      end
   end

   // Build the job for this request.
   always_comb begin
      job_data       = '0;
      job_data.valid = 1'b1;
      job_data.last  = req_data.end_of_text;
      job_push       = 1'b0;
      if (full_group) begin
         job_data.data = {sextet_store_ff, sx[5:0]};
         job_data.nres = NRES_THREE;
         job_push      = accept;
      end else if (req_data.end_of_text) begin
         job_push = accept;
         unique case (gc_step)
            2'd2: begin
               job_data.data = {st_step[11:4], 16'h0000};
               job_data.nres = NRES_ONE;
            end
            2'd3: begin
               job_data.data = {st_step[17:10], st_step[9:2], 8'h00};
               job_data.nres = NRES_TWO;
            end
            default: begin
               job_data.nres  = NRES_ONE;
               job_data.valid = 1'b0;
            end
         endcase
      end
   end

   // Hold group state between requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff  <= 2'd0;
         sextet_store_ff <= 18'd0;
         halted_ff       <= 1'b0;
      end else if (accept) begin
         group_count_ff  <= group_count_in;
         sextet_store_ff <= sextet_store_in;
         halted_ff       <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
`default_nettype none
`include "base64_stream_decoder_core_macros.svh"

module b64d_queue #(
   parameter int DEPTH = b64d_pkg::JOB_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire b64d_pkg::job_type    push_data,
   input  wire logic                 pop,
   output b64d_pkg::job_type         pop_data,
   output b64d_pkg::q_stat_type      stat
);
   import b64d_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Advance pointers and count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `B64D_ASSERT(a_count_bound, count_ff <= FULL_CNT, "job queue count over depth")
   `B64D_ASSERT(a_push_grows, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CW'(1)), "job queue count did not grow on push")
   `B64D_ASSERT(a_idle_rd_hold, (!pop && !do_push) |=> $stable(rd_ptr_ff) && $stable(count_ff), "job queue moved without a request")

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
`default_nettype none
`include "base64_stream_decoder_core_macros.svh"

module b64d_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b64d_pkg::q_stat_type q_stat,
   input  wire b64d_pkg::job_type    job_data,
   output logic                      job_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output b64d_pkg::rsp_type         rsp_data
);
   import b64d_pkg::*;

   job_type    cur_job_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] cur_idx_ff, cur_idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic       out_load, cur_end, cur_take;

   // Move one byte into the output register when it frees up.
   assign out_load = cur_valid_ff && (!out_valid_ff || rsp_pop);
   assign cur_end  = (cur_idx_ff == cur_job_ff.nres - 2'd1);
   assign cur_take = !cur_valid_ff || (out_load && cur_end);
   assign job_pop  = cur_take && !q_stat.empty;

   // Select the byte of the current job.
   always_comb begin
      out_in = out_ff;
      if (out_load) begin
         unique case (cur_idx_ff)
            2'd0:    out_in.byte_out = cur_job_ff.data[23:16];
            2'd1:    out_in.byte_out = cur_job_ff.data[15:8];
            default: out_in.byte_out = cur_job_ff.data[7:0];
         endcase
         out_in.byte_valid = cur_job_ff.valid;
         out_in.last       = cur_job_ff.last && cur_end;
      end
   end

   // Advance the job and output flags.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_idx_in   = cur_idx_ff;
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         cur_idx_in   = cur_idx_ff + 2'd1;
      end
      if (cur_take) begin
         cur_valid_in = !q_stat.empty;
         cur_idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_idx_ff   <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_idx_ff   <= cur_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (job_pop) begin
         cur_job_ff <= job_data;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   `B64D_ASSERT(a_idx_in_job, cur_valid_ff |-> (cur_idx_ff < cur_job_ff.nres), "byte index past job")
   `B64D_ASSERT(a_stall_hold, (out_valid_ff && !rsp_pop) |=> $stable(out_ff) && !rsp_empty, "waiting response changed")
   `B64D_ASSERT(a_empty_byte_last, (out_valid_ff && !out_ff.byte_valid) |-> out_ff.last, "empty byte without last mark")

endmodule

`default_nettype wire
